### hw/rtl/msit_pkg.sv
// Shared types and field widths for the multi-slot interval timer.
package msit_pkg;

  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned DUR_W   = 32;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned CFG_W   = 32;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

endpackage

### hw/rtl/msit_in_if.sv
// Input channel of the multi-slot interval timer: valid, ready and the item fields.
interface msit_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic [msit_pkg::SLOT_W-1:0]         slot;
  logic [msit_pkg::DUR_W-1:0]          duration;
  logic                                repeat_req;
  logic [msit_pkg::DELTA_W-1:0]        delta;

  modport source (output valid, mode, slot, duration, repeat_req, delta, input ready);
  modport sink   (input valid, mode, slot, duration, repeat_req, delta, output ready);
endinterface

### hw/rtl/msit_out_if.sv
// Result channel of the multi-slot interval timer: valid, ready and the result fields.
interface msit_out_if;
  logic                                valid;
  logic                                ready;
  logic [msit_pkg::MASK_W-1:0]         fired_mask;
  logic                                housekeeping_fired;

  modport source (output valid, fired_mask, housekeeping_fired, input ready);
  modport sink   (input valid, fired_mask, housekeeping_fired, output ready);
endinterface

### hw/rtl/multi_slot_interval_timer_core.sv
// Top level of the multi-slot interval timer: slot bank, housekeeping counter, result register.
// A beat passes through the input register, then the result register, to its result beat.
// Throughput: one beat per cycle unless the result channel stalls; every slot has its own adder and compare.
// Reset: all slots inactive, counts and housekeeping interval zero, both channels empty.
// Slot durations and repeat flags are not reset; they are read only for started slots.
module multi_slot_interval_timer_core #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [msit_pkg::CFG_W-1:0]   cfg_wdata_i,
  msit_in_if.sink                      in_i,
  msit_out_if.source                   out_o
);

  localparam int unsigned SUM_W = TIME_WIDTH + 1;
  localparam int unsigned EXT_W = ((TIME_WIDTH > msit_pkg::DUR_W) ? TIME_WIDTH
                                                                  : msit_pkg::DUR_W) + 1;
  localparam logic [EXT_W-1:0] TIME_MAX_EXT =
    {{(EXT_W-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};

  typedef logic [TIME_WIDTH-1:0] time_t;

  // input register
  logic                          in_valid_q;
  msit_pkg::mode_e               mode_q;
  logic [msit_pkg::SLOT_W-1:0]   slot_q;
  logic [msit_pkg::DUR_W-1:0]    duration_q;
  logic                          repeat_q;
  logic [msit_pkg::DELTA_W-1:0]  delta_q;

  // result register
  logic                          out_valid_q;
  logic [msit_pkg::MASK_W-1:0]   mask_q, mask_d;
  logic                          hk_fired_q, hk_fired_d;

  // state
  logic [msit_pkg::CFG_W-1:0]    interval_q;
  time_t                         count_q  [NUM_SLOTS];
  time_t                         count_d  [NUM_SLOTS];
  time_t                         dur_q    [NUM_SLOTS];
  time_t                         dur_d    [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]          rep_q, rep_d;
  logic [NUM_SLOTS-1:0]          active_q, active_d;
  time_t                         hk_count_q, hk_count_d;

  logic                          out_free;
  logic                          adv;
  logic                          in_acc;
  logic [NUM_SLOTS-1:0]          slot_hit;
  logic [NUM_SLOTS-1:0]          fired;
  logic [SUM_W-1:0]              slot_sum [NUM_SLOTS];
  time_t                         slot_new [NUM_SLOTS];
  logic [SUM_W-1:0]              hk_sum;
  time_t                         hk_new;
  logic [EXT_W-1:0]              dur_ext;
  time_t                         dur_sat;
  logic [EXT_W-1:0]              intv_ext;
  time_t                         intv_sat;

  assign out_free   = !out_valid_q || out_o.ready;
  assign adv        = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  // saturate wide values to the time range
  assign dur_ext  = EXT_W'(duration_q);
  assign dur_sat  = (dur_ext > TIME_MAX_EXT) ? '1 : dur_ext[TIME_WIDTH-1:0];
  assign intv_ext = EXT_W'(interval_q);
  assign intv_sat = (intv_ext > TIME_MAX_EXT) ? '1 : intv_ext[TIME_WIDTH-1:0];

  assign hk_sum = {1'b0, hk_count_q} + SUM_W'(delta_q);
  assign hk_new = hk_sum[TIME_WIDTH] ? '1 : hk_sum[TIME_WIDTH-1:0];

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_hit[i] = (int'(slot_q) == i);
      slot_sum[i] = {1'b0, count_q[i]} + SUM_W'(delta_q);
      slot_new[i] = slot_sum[i][TIME_WIDTH] ? '1 : slot_sum[i][TIME_WIDTH-1:0];
    end
  end

  always_comb begin
    count_d    = count_q;
    dur_d      = dur_q;
    rep_d      = rep_q;
    active_d   = active_q;
    hk_count_d = hk_count_q;
    hk_fired_d = 1'b0;
    fired      = '0;
    unique case (mode_q)
      msit_pkg::MODE_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (active_q[i]) begin
            count_d[i] = slot_new[i];
            if (slot_new[i] >= dur_q[i]) begin
              fired[i] = 1'b1;
              if (rep_q[i]) begin
                count_d[i] = '0;
              end else begin
                active_d[i] = 1'b0;
              end
            end
          end
        end
        if (hk_new >= intv_sat) begin
          hk_count_d = '0;
          hk_fired_d = 1'b1;
        end else begin
          hk_count_d = hk_new;
        end
      end
      msit_pkg::MODE_START: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_hit[i]) begin
            dur_d[i]    = dur_sat;
            rep_d[i]    = repeat_q;
            count_d[i]  = '0;
            active_d[i] = 1'b1;
          end
        end
      end
      msit_pkg::MODE_CLEAR: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_hit[i]) begin
            active_d[i] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < msit_pkg::MASK_W; g++) begin : g_mask
    if (g < NUM_SLOTS) begin : g_live
      assign mask_d[g] = fired[g];
    end else begin : g_none
      assign mask_d[g] = 1'b0;
    end
  end

  // control and reset-cleared state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      interval_q  <= '0;
      active_q    <= '0;
      hk_count_q  <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (adv) begin
        active_q   <= active_d;
        hk_count_q <= hk_count_d;
        count_q    <= count_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q     <= msit_pkg::mode_e'(in_i.mode);
      slot_q     <= in_i.slot;
      duration_q <= in_i.duration;
      repeat_q   <= in_i.repeat_req;
      delta_q    <= in_i.delta;
    end
    if (adv) begin
      dur_q      <= dur_d;
      rep_q      <= rep_d;
      mask_q     <= mask_d;
      hk_fired_q <= hk_fired_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.fired_mask         = mask_q;
  assign out_o.housekeeping_fired = hk_fired_q;

  a_non_tick_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && mode_q != msit_pkg::MODE_TICK) |=>
      (out_valid_q && mask_q == '0 && !hk_fired_q))
    else $error("start or clear beat gave a non-empty result");

  a_tick_no_activate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && mode_q == msit_pkg::MODE_TICK) |=> ((active_q & ~$past(active_q)) == '0))
    else $error("tick beat activated a slot");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while both registers are full and stalled");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(active_q) && $stable(hk_count_q)))
    else $error("slot state changed without a beat advancing");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the multi-slot interval timer core.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0]  MODE_NOP        = 2'd3;
  localparam int unsigned SLOTS           = 16;
  localparam int unsigned ITEMS_PER_PHASE = 120;
  localparam int unsigned PHASES          = 6;

  typedef struct packed {
    logic [msit_pkg::MASK_W-1:0] mask;
    logic                        hk;
  } fire_t;

  class slot_fire_tracker;
    logic [msit_pkg::DUR_W-1:0] slot_cnt [SLOTS];
    logic [msit_pkg::DUR_W-1:0] slot_dur [SLOTS];
    logic                       slot_rpt [SLOTS];
    logic                       slot_on  [SLOTS];
    logic [msit_pkg::DUR_W-1:0] hk_cnt;
    logic [msit_pkg::CFG_W-1:0] hk_interval;
    fire_t                      due_fires [$];
    int unsigned                errors;
    int unsigned                items;
    int unsigned                results;
    int unsigned                slot_fires;
    int unsigned                hk_fires;

    function new();
      hk_cnt      = '0;
      hk_interval = '0;
      errors      = 0;
      items       = 0;
      results     = 0;
      slot_fires  = 0;
      hk_fires    = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_cnt[i] = '0;
        slot_dur[i] = '0;
        slot_rpt[i] = 1'b0;
        slot_on[i]  = 1'b0;
      end
    endfunction

    function void set_interval(logic [msit_pkg::CFG_W-1:0] v);
      hk_interval = v;
    endfunction

    function logic [msit_pkg::DUR_W-1:0] sat_add(logic [msit_pkg::DUR_W-1:0] a,
                                                 logic [msit_pkg::DELTA_W-1:0] b);
      logic [msit_pkg::DUR_W:0] s;
      s = {1'b0, a} + {{(msit_pkg::DUR_W + 1 - msit_pkg::DELTA_W){1'b0}}, b};
      return s[msit_pkg::DUR_W] ? '1 : s[msit_pkg::DUR_W-1:0];
    endfunction

    function void take_item(logic [1:0] md, logic [msit_pkg::SLOT_W-1:0] sl,
                            logic [msit_pkg::DUR_W-1:0] dur, logic rpt,
                            logic [msit_pkg::DELTA_W-1:0] dl);
      fire_t f;
      f = '0;
      items++;
      unique case (md)
        msit_pkg::MODE_START: begin
          slot_dur[sl] = dur;
          slot_rpt[sl] = rpt;
          slot_cnt[sl] = '0;
          slot_on[sl]  = 1'b1;
        end
        msit_pkg::MODE_CLEAR: begin
          slot_on[sl] = 1'b0;
        end
        msit_pkg::MODE_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_on[i]) begin
              slot_cnt[i] = sat_add(slot_cnt[i], dl);
              if (slot_cnt[i] >= slot_dur[i]) begin
                f.mask[i] = 1'b1;
                if (slot_rpt[i]) begin
                  slot_cnt[i] = '0;
                end else begin
                  slot_on[i] = 1'b0;
                end
              end
            end
          end
          hk_cnt = sat_add(hk_cnt, dl);
          if (hk_cnt >= hk_interval) begin
            hk_cnt = '0;
            f.hk   = 1'b1;
          end
        end
        default: ;
      endcase
      due_fires.push_back(f);
    endfunction

    function void check_fire(logic [msit_pkg::MASK_W-1:0] mask, logic hk);
      fire_t want;
      results++;
      if (due_fires.size() == 0) begin
        errors++;
        $display("%0t: result beat expected none, actual mask %h housekeeping %b",
                 $time, mask, hk);
        return;
      end
      want = due_fires.pop_front();
      if (mask !== want.mask) begin
        errors++;
        $display("%0t: fired_mask expected %h, actual %h", $time, want.mask, mask);
      end
      if (hk !== want.hk) begin
        errors++;
        $display("%0t: housekeeping_fired expected %b, actual %b", $time, want.hk, hk);
      end
      slot_fires += $countones(want.mask);
      if (want.hk) begin
        hk_fires++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [msit_pkg::CFG_W-1:0] cfg_wdata_i;

  msit_in_if  in_ch ();
  msit_out_if out_ch ();

  slot_fire_tracker sb = new();
  bit               tx_idle;
  bit               rx_idle;
  bit               hold_req;
  int unsigned      hold_len;
  int unsigned      n_settings;

  multi_slot_interval_timer_core u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_item(input logic [1:0] md, input logic [msit_pkg::SLOT_W-1:0] sl,
                           input logic [msit_pkg::DUR_W-1:0] dur, input logic rpt,
                           input logic [msit_pkg::DELTA_W-1:0] dl);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= md;
    in_ch.slot       <= sl;
    in_ch.duration   <= dur;
    in_ch.repeat_req <= rpt;
    in_ch.delta      <= dl;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.take_item(md, sl, dur, rpt, dl);
  endtask

  task automatic send_random_item();
    int unsigned                  pick;
    int unsigned                  r;
    logic [1:0]                   md;
    logic [msit_pkg::SLOT_W-1:0]  sl;
    logic [msit_pkg::DUR_W-1:0]   dur;
    logic                         rpt;
    logic [msit_pkg::DELTA_W-1:0] dl;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      md = msit_pkg::MODE_TICK;
    end else if (pick < 78) begin
      md = msit_pkg::MODE_START;
    end else if (pick < 95) begin
      md = msit_pkg::MODE_CLEAR;
    end else begin
      md = MODE_NOP;
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      dur = $urandom_range(0, 300);
    end else if (pick < 9) begin
      dur = $urandom_range(0, 5000);
    end else begin
      dur = $urandom();
    end
    pick = $urandom_range(0, 19);
    r    = (pick < 17) ? $urandom_range(0, 60) : $urandom_range(0, 65535);
    dl   = r[msit_pkg::DELTA_W-1:0];
    r    = $urandom_range(0, SLOTS - 1);
    sl   = r[msit_pkg::SLOT_W-1:0];
    r    = $urandom_range(0, 1);
    rpt  = r[0];
    send_item(md, sl, dur, rpt, dl);
  endtask

  // drop valid, then let every outstanding beat come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.due_fires.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [msit_pkg::CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_interval(v);
    n_settings++;
  endtask

  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      if (hold_req) begin
        stall    = hold_len;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      sb.check_fire(out_ch.fired_mask, out_ch.housekeeping_fired);
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= msit_pkg::MODE_TICK;
    in_ch.slot       <= '0;
    in_ch.duration   <= '0;
    in_ch.repeat_req <= 1'b0;
    in_ch.delta      <= '0;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    hold_req         = 1'b0;
    hold_len         = 0;
    n_settings       = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // interval still at its reset value, so housekeeping fires on every tick
    send_item(msit_pkg::MODE_TICK,  4'd0,  32'd0,          1'b0, 16'd0);
    send_item(msit_pkg::MODE_START, 4'd0,  32'd0,          1'b0, 16'hFFFF);
    send_item(msit_pkg::MODE_TICK,  4'd0,  32'd0,          1'b0, 16'd0);
    send_item(msit_pkg::MODE_TICK,  4'd0,  32'd0,          1'b0, 16'hFFFF);
    send_item(msit_pkg::MODE_START, 4'd15, 32'hFFFF_FFFF,  1'b1, 16'd0);
    send_item(msit_pkg::MODE_START, 4'd1,  32'd5,          1'b1, 16'd0);
    send_item(msit_pkg::MODE_TICK,  4'd0,  32'd0,          1'b0, 16'd7);
    send_item(msit_pkg::MODE_TICK,  4'd0,  32'd0,          1'b0, 16'd5);
    send_item(msit_pkg::MODE_START, 4'd2,  32'd10,         1'b0, 16'd0);
    send_item(msit_pkg::MODE_START, 4'd2,  32'd20,         1'b0, 16'd0);
    send_item(msit_pkg::MODE_TICK,  4'd0,  32'd0,          1'b0, 16'd15);
    send_item(msit_pkg::MODE_TICK,  4'd0,  32'd0,          1'b0, 16'd5);
    send_item(msit_pkg::MODE_CLEAR, 4'd1,  32'd0,          1'b0, 16'd0);
    send_item(msit_pkg::MODE_CLEAR, 4'd3,  32'd0,          1'b0, 16'd0);
    send_item(msit_pkg::MODE_TICK,  4'd0,  32'd0,          1'b0, 16'd4);
    send_item(MODE_NOP,             4'hF,  32'hFFFF_FFFF,  1'b1, 16'hFFFF);
    send_item(msit_pkg::MODE_START, 4'd7,  32'd1,          1'b0, 16'd0);
    send_item(msit_pkg::MODE_START, 4'd8,  32'd1,          1'b1, 16'd0);
    send_item(msit_pkg::MODE_TICK,  4'd0,  32'd0,          1'b0, 16'd1);
    send_item(msit_pkg::MODE_TICK,  4'd0,  32'd0,          1'b0, 16'd1);
    send_item(msit_pkg::MODE_START, 4'd15, 32'hFFFF_FFFF,  1'b1, 16'hFFFF);
    send_item(msit_pkg::MODE_CLEAR, 4'd15, 32'hFFFF_FFFF,  1'b1, 16'hFFFF);
    send_item(msit_pkg::MODE_TICK,  4'hF,  32'hFFFF_FFFF,  1'b1, 16'hFFFF);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      unique case (p)
        0: begin
          write_interval(32'hFFFF_FFFF);
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
        1: begin
          write_interval(32'd150);
          tx_idle = 1'b1;
          rx_idle = 1'b0;
        end
        2: begin
          write_interval(32'd0);
          tx_idle = 1'b0;
          rx_idle = 1'b1;
        end
        3: begin
          write_interval($urandom_range(1, 2000));
          tx_idle  = 1'b0;
          rx_idle  = 1'b0;
          hold_len = 60;
          hold_req = 1'b1;
        end
        4: begin
          write_interval($urandom());
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
        default: begin
          write_interval(32'd1);
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_random_item();
      wait_idle();
    end

    $display("Checked %0d result beats for %0d items: %0d slot firings, %0d housekeeping pulses.",
             sb.results, sb.items, sb.slot_fires, sb.hk_fires);
    $display("Covered %0d interval settings from zero to all ones, with idle gaps and a long hold.",
             n_settings);
    if (sb.errors == 0 && sb.due_fires.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d beats outstanding", sb.due_fires.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
